// ===== rtl/core/pdb_pkg.sv =====
// Shared constants, types and lane interface structs for the per-row debounce block.
`timescale 1ns / 1ps

package pdb_pkg;

	localparam int ROWS        = 8;
	localparam int COLS        = 8;
	localparam int STAMP_WIDTH = 16;
	localparam int ROW_STRIDE  = 8;
	localparam int MATRIX_W    = 64;
	localparam int NOW_W       = 16;
	localparam int CNT_W       = 8;

	localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(5);
	localparam logic [CNT_W-1:0] ELAPSED_CLAMP  = CNT_W'(255);

	typedef logic [COLS-1:0]        row_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [STAMP_WIDTH-1:0] stamp_t;
	typedef logic [MATRIX_W-1:0]    matrix_t;

	// Broadcast from the top level to every lane.
	typedef struct packed {
		logic accept;
		logic do_sub;
		logic changed;
		cnt_t elapsed;
		cnt_t start;
	} lane_ctrl_t;

	// What one lane found for its row in this transaction.
	typedef struct packed {
		logic remaining;
		logic differ;
		logic row_changed;
	} lane_stat_t;

endpackage

// ===== rtl/core/pdb_lane.sv =====
// One row lane: countdown and debounced state of a single matrix row.
`timescale 1ns / 1ps

module pdb_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  pdb_pkg::lane_ctrl_t ctrl,
	input  pdb_pkg::row_t       raw,
	output pdb_pkg::row_t       deb_next,
	output pdb_pkg::lane_stat_t stat
);

	pdb_pkg::cnt_t cd_q;
	pdb_pkg::row_t deb_q;
	pdb_pkg::cnt_t cd_sub;
	pdb_pkg::cnt_t cd_next;
	logic          differ;
	logic          row_chg;

	always_comb begin
		cd_sub   = cd_q;
		deb_next = deb_q;
		row_chg  = 1'b0;
		if (ctrl.do_sub && (cd_q != '0)) begin
			if (cd_q <= ctrl.elapsed) begin
				cd_sub   = '0;
				row_chg  = (deb_q != raw);
				deb_next = raw;
			end else begin
				cd_sub = cd_q - ctrl.elapsed;
			end
		end
		differ = (raw != deb_next);
		// A changed scan restarts a differing row and drops the countdown of any other.
		if (ctrl.changed) begin
			cd_next = differ ? ctrl.start : '0;
		end else begin
			cd_next = cd_sub;
		end
	end

	assign stat.remaining   = (cd_sub != '0);
	assign stat.differ      = differ;
	assign stat.row_changed = row_chg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q  <= '0;
			deb_q <= '0;
		end else if (ctrl.accept) begin
			cd_q  <= cd_next;
			deb_q <= deb_next;
		end
	end

endmodule

// ===== rtl/core/pdb_merge.sv =====
// Merging stage: combines the lane results into the matrix, change flag and pending flag.
`timescale 1ns / 1ps

module pdb_merge (
	input  pdb_pkg::lane_stat_t stat     [pdb_pkg::ROWS],
	input  pdb_pkg::row_t       deb_rows [pdb_pkg::ROWS],
	input  logic                was_pending,
	input  logic                elapsed_nz,
	input  logic                changed_in,
	output logic                pending_next,
	output logic                any_changed,
	output pdb_pkg::matrix_t    matrix
);

	logic any_rem;
	logic any_differ;

	always_comb begin
		any_rem     = 1'b0;
		any_differ  = 1'b0;
		any_changed = 1'b0;
		matrix      = '0;
		for (int r = 0; r < pdb_pkg::ROWS; r++) begin
			any_rem     = any_rem | stat[r].remaining;
			any_differ  = any_differ | stat[r].differ;
			any_changed = any_changed | stat[r].row_changed;
			matrix[r*pdb_pkg::ROW_STRIDE +: pdb_pkg::COLS] = deb_rows[r];
		end
		// With no time elapsed a set pending flag stays set; a changed scan with a differing row also sets it.
		pending_next = (was_pending && (elapsed_nz ? any_rem : 1'b1))
			|| (changed_in && any_differ);
	end

endmodule

// ===== rtl/core/per_row_deferred_debounce_top.sv =====
// Top level of the per-row deferred key-matrix debounce block.
`timescale 1ns / 1ps

// Each transaction on the slave side carries one key-matrix scan and yields one
// result on the master side: the debounced matrix and whether any row changed.
// All rows are handled side by side by one lane each, so a new scan is accepted
// every cycle as long as the output register is empty or being drained in the
// same cycle. The result is registered and appears in the cycle after acceptance.
// debounce_ms resets to 5; writing 0 behaves as 1. Unused bits of the debounced
// matrix read as zero.
module per_row_deferred_debounce_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: raw_matrix[63:0], scan_changed[64], now_ms[80:65], zero pad.
	input  logic [87:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: debounced_matrix[63:0], debounced_changed[64], zero pad.
	output logic [71:0] m_tdata
);

	pdb_pkg::cnt_t       debounce_q;
	logic                pending_q;
	pdb_pkg::stamp_t     stamp_q;
	logic                out_valid_q;
	pdb_pkg::matrix_t    out_matrix_q;
	logic                out_changed_q;

	pdb_pkg::matrix_t    raw;
	logic                changed_in;
	logic [pdb_pkg::NOW_W-1:0] now_in;
	pdb_pkg::stamp_t     now_st;
	pdb_pkg::stamp_t     diff;
	logic                accept;
	logic                elapsed_nz;
	pdb_pkg::lane_ctrl_t ctrl;
	pdb_pkg::lane_stat_t stat     [pdb_pkg::ROWS];
	pdb_pkg::row_t       deb_rows [pdb_pkg::ROWS];
	logic                pending_next;
	logic                any_changed;
	pdb_pkg::matrix_t    matrix;

	assign raw        = s_tdata[63:0];
	assign changed_in = s_tdata[64];
	assign now_in     = s_tdata[80:65];
	assign now_st     = pdb_pkg::stamp_t'(now_in);
	assign diff       = now_st - stamp_q;
	assign elapsed_nz = (diff != '0);

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		ctrl.accept  = accept;
		ctrl.do_sub  = pending_q && elapsed_nz;
		ctrl.changed = changed_in;
		ctrl.start   = (debounce_q == '0) ? pdb_pkg::cnt_t'(1) : debounce_q;
		if (diff > pdb_pkg::stamp_t'(pdb_pkg::ELAPSED_CLAMP)) begin
			ctrl.elapsed = pdb_pkg::ELAPSED_CLAMP;
		end else begin
			ctrl.elapsed = diff[pdb_pkg::CNT_W-1:0];
		end
	end

	for (genvar r = 0; r < pdb_pkg::ROWS; r++) begin : g_lane
		pdb_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.raw      (raw[r*pdb_pkg::ROW_STRIDE +: pdb_pkg::COLS]),
			.deb_next (deb_rows[r]),
			.stat     (stat[r])
		);
	end

	pdb_merge u_merge (
		.stat         (stat),
		.deb_rows     (deb_rows),
		.was_pending  (pending_q),
		.elapsed_nz   (elapsed_nz),
		.changed_in   (changed_in),
		.pending_next (pending_next),
		.any_changed  (any_changed),
		.matrix       (matrix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= pdb_pkg::DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			stamp_q   <= '0;
		end else if (accept) begin
			pending_q <= pending_next;
			// The stamp is taken on every pending step and on a changed scan.
			if (pending_q || changed_in) begin
				stamp_q <= now_st;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_matrix_q  <= matrix;
			out_changed_q <= any_changed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_changed_q, out_matrix_q};

endmodule
